// ===== hdl/orm_uf_pkg.sv =====
// shared constants and types for the offline range-minimum core
package orm_uf_pkg;
   localparam int MAX_LEN    = 1024;
   localparam int ADDR_W     = $clog2(MAX_LEN);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int DATA_WIDTH = 16;

   typedef enum logic [1:0] {
      KIND_APPEND = 2'd0,
      KIND_QUERY  = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOT_LOAD = 2'd1,
      ST_FULL     = 2'd2
   } status_type;
endpackage

// ===== hdl/offline_range_min_union_find_core.sv =====
// offline range-minimum core: monotone stack plus union-find with path compression
//
//  channel   ports                                            handshake
//  request   req_kind req_value req_query_left req_query_tag  start & !busy
//  response  rsp_min_value rsp_min_index rsp_answer_tag       rsp_valid, one cycle
//            rsp_status
//
// an append reads the stack top and its value and pops each strictly larger
// entry, linking it to the new slot, before it pushes; a query walks up to the
// root and then runs a compression pass; the find walk and the compression
// pass both visit each link. the single-port reads of the stack, parent and
// value memories set the pace of these steps. clear, unused and error words
// finish without leaving idle, and an error answer shows in the next cycle.
// reset empties the array at once.
// the receiver cannot stall; each result shows for one cycle.
module offline_range_min_union_find_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic signed [15:0] req_value,
   input  logic [9:0]  req_query_left,
   input  logic [15:0] req_query_tag,
   output logic        rsp_valid,
   output logic signed [15:0] rsp_min_value,
   output logic [9:0]  rsp_min_index,
   output logic [15:0] rsp_answer_tag,
   output logic [1:0]  rsp_status
);
   localparam int AW = orm_uf_pkg::ADDR_W;
   localparam int CW = orm_uf_pkg::CNT_W;
   localparam int DW = orm_uf_pkg::DATA_WIDTH;

   typedef enum logic [3:0] {
      S_IDLE, S_POP_RD, S_POP_CMP, S_PUSH, S_F_RD, S_F_CHK, S_C_RD, S_C_WR,
      S_V_RD, S_V_OUT
   } state_type;

   // memories
   logic signed [DW-1:0] value_mem [orm_uf_pkg::MAX_LEN];
   logic [AW-1:0] parent_mem [orm_uf_pkg::MAX_LEN];
   logic [AW-1:0] stack_mem [orm_uf_pkg::MAX_LEN];

   state_type state_ff;
   logic [CW-1:0] depth_ff, count_ff;
   logic signed [DW-1:0] val_ff;
   logic [AW-1:0] left_ff, cur_ff, root_ff, top_ff;
   logic [AW-1:0] par_rd_ff, stk_rd_ff;
   logic signed [DW-1:0] val_rd_ff;
   logic [CW-1:0] depth_m1;

   assign depth_m1 = depth_ff - CW'(1);
   assign busy = (state_ff != S_IDLE);

   // memory ports, written and read in one clocked block
   logic val_we, par_we, stk_we;
   logic [AW-1:0] val_addr, par_addr, par_wd, stk_addr;
   always_comb begin
      val_we = 1'b0; par_we = 1'b0; stk_we = 1'b0;
      val_addr = cur_ff; par_addr = cur_ff; par_wd = root_ff;
      stk_addr = depth_m1[AW-1:0];
      unique case (state_ff)
         S_POP_RD:  val_addr = stk_rd_ff;
         S_POP_CMP: begin
            par_addr = top_ff; par_wd = count_ff[AW-1:0];
            par_we = (val_rd_ff > val_ff);
            // fetch the entry below the top in case this one pops
            stk_addr = depth_ff[AW-1:0] - AW'(2);
         end
         S_PUSH: begin
            val_we = 1'b1; val_addr = count_ff[AW-1:0];
            par_we = 1'b1; par_addr = count_ff[AW-1:0]; par_wd = count_ff[AW-1:0];
            stk_we = 1'b1; stk_addr = depth_ff[AW-1:0];
         end
         S_C_WR:    par_we = 1'b1;
         S_V_RD:    val_addr = root_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (val_we) value_mem[val_addr] <= val_ff;
      val_rd_ff <= value_mem[val_addr];
      if (par_we) parent_mem[par_addr] <= par_wd;
      par_rd_ff <= parent_mem[par_addr];
      if (stk_we) stack_mem[stk_addr] <= count_ff[AW-1:0];
      stk_rd_ff <= stack_mem[stk_addr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         depth_ff  <= '0;
         count_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (start) begin
               val_ff  <= req_value;
               left_ff <= req_query_left;
               cur_ff  <= req_query_left;
               rsp_answer_tag <= req_query_tag;
               rsp_min_value  <= '0;
               rsp_min_index  <= '0;
               case (orm_uf_pkg::kind_type'(req_kind))
                  orm_uf_pkg::KIND_APPEND:
                     if (count_ff == CW'(orm_uf_pkg::MAX_LEN)) begin
                        rsp_status <= orm_uf_pkg::ST_FULL;
                        rsp_valid  <= 1'b1;
                     end else if (depth_ff == '0) state_ff <= S_PUSH;
                     else state_ff <= S_POP_RD;
                  orm_uf_pkg::KIND_QUERY:
                     if (CW'(req_query_left) >= count_ff) begin
                        rsp_status <= orm_uf_pkg::ST_NOT_LOAD;
                        rsp_valid  <= 1'b1;
                     end else state_ff <= S_F_RD;
                  orm_uf_pkg::KIND_CLEAR: begin
                     count_ff <= '0;
                     depth_ff <= '0;
                  end
                  default: ;
               endcase
            end
            // stack top address was read; now fetch its value
            S_POP_RD: begin
               top_ff   <= stk_rd_ff;
               state_ff <= S_POP_CMP;
            end
            S_POP_CMP:
               if (val_rd_ff > val_ff) begin
                  depth_ff <= depth_m1;
                  state_ff <= (depth_m1 == '0) ? S_PUSH : S_POP_RD;
               end else state_ff <= S_PUSH;
            S_PUSH: begin
               depth_ff <= depth_ff + CW'(1);
               count_ff <= count_ff + CW'(1);
               state_ff <= S_IDLE;
            end
            // find: read parent of cur
            S_F_RD: state_ff <= S_F_CHK;
            S_F_CHK:
               if (par_rd_ff == cur_ff) begin
                  root_ff  <= cur_ff;
                  cur_ff   <= left_ff;
                  state_ff <= S_C_RD;
               end else begin
                  cur_ff   <= par_rd_ff;
                  state_ff <= S_F_RD;
               end
            // compression: read next, then point cur at root
            S_C_RD:
               state_ff <= (cur_ff == root_ff) ? S_V_RD : S_C_WR;
            S_C_WR: begin
               cur_ff   <= par_rd_ff;
               state_ff <= S_C_RD;
            end
            S_V_RD: state_ff <= S_V_OUT;
            S_V_OUT: begin
               rsp_min_value <= val_rd_ff;
               rsp_min_index <= root_ff;
               rsp_status    <= orm_uf_pkg::ST_OK;
               rsp_valid     <= 1'b1;
               state_ff      <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== verif/offline_range_min_union_find_core_checker.sv =====
// checker for the range-minimum core: tracks the element array and compares answer words
module offline_range_min_union_find_core_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [1:0]        req_kind,
   input  logic signed [15:0] req_value,
   input  logic [9:0]        req_query_left,
   input  logic [15:0]       req_query_tag,
   input  logic              rsp_valid,
   input  logic signed [15:0] rsp_min_value,
   input  logic [9:0]        rsp_min_index,
   input  logic [15:0]       rsp_answer_tag,
   input  logic [1:0]        rsp_status,
   output int                fail_count,
   output int                pending_answers,
   output int                elem_count
);
   typedef struct packed {
      logic signed [15:0]     min_value;
      logic [9:0]             min_index;
      logic [15:0]            tag;
      orm_uf_pkg::status_type status;
   } answer_word_type;

   logic signed [15:0] elem_value [orm_uf_pkg::MAX_LEN];
   logic [orm_uf_pkg::ADDR_W-1:0] root_link  [orm_uf_pkg::MAX_LEN];
   logic [orm_uf_pkg::ADDR_W-1:0] mono_stack [orm_uf_pkg::MAX_LEN];
   int                 mono_depth;
   int                 num_elems;
   int                 predicted_answers;
   int                 seen_answers;
   answer_word_type    answer_queue [$];

   assign pending_answers = predicted_answers - seen_answers;
   assign elem_count      = num_elems;

   // union-find root lookup with full path compression
   function automatic logic [orm_uf_pkg::ADDR_W-1:0] find_min_root(
      input logic [orm_uf_pkg::ADDR_W-1:0] start_pos);
      logic [orm_uf_pkg::ADDR_W-1:0] r, c, nx;
      r = start_pos;
      while (root_link[r] != r) r = root_link[r];
      c = start_pos;
      while (c != r) begin
         nx = root_link[c];
         root_link[c] = r;
         c = nx;
      end
      return r;
   endfunction

   // predict on each accepted request word
   always @(posedge clock) begin
      answer_word_type w;
      logic [orm_uf_pkg::ADDR_W-1:0] root;
      if (reset) begin
         mono_depth = 0;
         num_elems  = 0;
         predicted_answers = 0;
         answer_queue.delete();
      end else if (start && !busy) begin
         w.tag = req_query_tag;
         case (orm_uf_pkg::kind_type'(req_kind))
            orm_uf_pkg::KIND_APPEND: begin
               if (num_elems >= orm_uf_pkg::MAX_LEN) begin
                  w.min_value = '0;
                  w.min_index = '0;
                  w.status    = orm_uf_pkg::ST_FULL;
                  answer_queue = {answer_queue, w};
                  predicted_answers++;
               end else begin
                  // pop strictly larger entries and link them to the new slot
                  while (mono_depth > 0 &&
                         elem_value[mono_stack[mono_depth-1]] > req_value) begin
                     root_link[mono_stack[mono_depth-1]] =
                        num_elems[orm_uf_pkg::ADDR_W-1:0];
                     mono_depth--;
                  end
                  elem_value[num_elems] = req_value;
                  root_link[num_elems]  = num_elems[orm_uf_pkg::ADDR_W-1:0];
                  mono_stack[mono_depth] = num_elems[orm_uf_pkg::ADDR_W-1:0];
                  mono_depth++;
                  num_elems++;
               end
            end
            orm_uf_pkg::KIND_QUERY: begin
               if (int'(req_query_left) >= num_elems) begin
                  w.min_value = '0;
                  w.min_index = '0;
                  w.status    = orm_uf_pkg::ST_NOT_LOAD;
               end else begin
                  root        = find_min_root(req_query_left);
                  w.min_value = elem_value[root];
                  w.min_index = root;
                  w.status    = orm_uf_pkg::ST_OK;
               end
               answer_queue = {answer_queue, w};
               predicted_answers++;
            end
            orm_uf_pkg::KIND_CLEAR: begin
               num_elems  = 0;
               mono_depth = 0;
            end
            default: ;
         endcase
      end
   end

   // compare each answer word with the oldest prediction
   always @(posedge clock) begin
      answer_word_type w;
      if (reset) begin
         fail_count   <= 0;
         seen_answers <= 0;
      end else if (rsp_valid) begin
         if (answer_queue.size() == 0) begin
            $display("%0t: unexpected answer value=%0d index=%0d tag=%0d status=%0d", $time,
                     rsp_min_value, rsp_min_index, rsp_answer_tag, rsp_status);
            fail_count <= fail_count + 1;
         end else begin
            w = answer_queue.pop_front();
            seen_answers <= seen_answers + 1;
            if (w.min_value !== rsp_min_value || w.min_index !== rsp_min_index ||
                w.tag !== rsp_answer_tag || w.status !== rsp_status) begin
               $display("%0t: expected value=%0d index=%0d tag=%0d status=%0d", $time,
                        w.min_value, w.min_index, w.tag, w.status);
               $display("%0t:   actual value=%0d index=%0d tag=%0d status=%0d", $time,
                        rsp_min_value, rsp_min_index, rsp_answer_tag, rsp_status);
               fail_count <= fail_count + 1;
            end
         end
      end
   end
endmodule

// ===== verif/offline_range_min_union_find_core_tb.sv =====
// testbench top for the range-minimum core: stimulus, watchdog and verdict
module offline_range_min_union_find_core_tb;
   localparam int WATCHDOG_LIMIT = 20000;

   logic              clock = 0;
   logic              reset = 1;
   logic              start = 0;
   logic              busy;
   logic [1:0]        req_kind = orm_uf_pkg::KIND_CLEAR;
   logic signed [15:0] req_value = '0;
   logic [9:0]        req_query_left = '0;
   logic [15:0]       req_query_tag = '0;
   logic              rsp_valid;
   logic signed [15:0] rsp_min_value;
   logic [9:0]        rsp_min_index;
   logic [15:0]       rsp_answer_tag;
   logic [1:0]        rsp_status;
   int                fail_count, pending_answers, elem_count;
   int                idle_pct = 38;
   int                stall_count = 0;

   always #1 clock = ~clock;

   offline_range_min_union_find_core dut (.*);

   offline_range_min_union_find_core_checker checker_i (.*);

   // watchdog: cycles in which no word moves on either channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
         $display("offline_range_min_union_find_core_tb failed");
         $finish;
      end
   end

   // send one request word, with a random gap first
   task automatic send_word(input orm_uf_pkg::kind_type kind, input logic [15:0] value,
                            input logic [9:0] left, input logic [15:0] tag);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_kind       <= kind;
      req_value      <= value;
      req_query_left <= left;
      req_query_tag  <= tag;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // query with a left index mostly inside the loaded range
   task automatic send_query();
      logic [9:0] left;
      if (elem_count > 0 && $urandom_range(9) != 0) left = 10'($urandom_range(elem_count - 1));
      else left = 10'($urandom);
      send_word(orm_uf_pkg::KIND_QUERY, 16'($urandom), left, 16'($urandom));
   endtask

   initial begin
      int n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty query, extremes, ties, unused kind
      send_word(orm_uf_pkg::KIND_QUERY, 16'h0, 10'd0, 16'hffff);
      send_word(orm_uf_pkg::KIND_QUERY, 16'h0, 10'h3ff, 16'h0000);
      send_word(orm_uf_pkg::KIND_APPEND, 16'h7fff, 10'h3ff, 16'h1);
      send_word(orm_uf_pkg::KIND_APPEND, 16'h8000, 10'h0, 16'h2);
      send_word(orm_uf_pkg::KIND_APPEND, 16'h8000, 10'h0, 16'h3);
      send_word(orm_uf_pkg::KIND_APPEND, 16'h0000, 10'h0, 16'h4);
      send_word(orm_uf_pkg::KIND_QUERY, 16'hffff, 10'd0, 16'h5555);
      send_word(orm_uf_pkg::KIND_QUERY, 16'h0, 10'd2, 16'haaaa);
      send_word(orm_uf_pkg::KIND_QUERY, 16'h0, 10'd3, 16'h1234);
      send_word(orm_uf_pkg::KIND_QUERY, 16'h0, 10'd4, 16'h4321);
      send_word(orm_uf_pkg::KIND_NONE, 16'hffff, 10'h3ff, 16'hffff);
      send_word(orm_uf_pkg::KIND_QUERY, 16'h0, 10'd1, 16'h7);
      send_word(orm_uf_pkg::KIND_CLEAR, 16'h0, 10'd0, 16'h8);
      send_word(orm_uf_pkg::KIND_QUERY, 16'h0, 10'd0, 16'h9);

      // random phases: sender idles 38%, then 76%, then not at all
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 38 : (phase == 1) ? 76 : 0;
         send_word(orm_uf_pkg::KIND_CLEAR, 16'h0, 10'd0, 16'h0);
         for (n = 0; n < 240; n++) begin
            case ($urandom_range(19))
               0: send_word(orm_uf_pkg::KIND_CLEAR, 16'($urandom), 10'($urandom),
                            16'($urandom));
               1: send_word(orm_uf_pkg::KIND_NONE, 16'($urandom), 10'($urandom),
                            16'($urandom));
               2, 3, 4, 5, 6, 7, 8: send_query();
               default: begin
                  // narrow values in places to force ties
                  if ($urandom_range(3) == 0)
                     send_word(orm_uf_pkg::KIND_APPEND, 16'($urandom_range(3)),
                               10'($urandom), 16'($urandom));
                  else send_word(orm_uf_pkg::KIND_APPEND, 16'($urandom), 10'($urandom),
                                 16'($urandom));
               end
            endcase
         end
         // hold off until every answer has come back
         start <= 1'b0;
         while (pending_answers != 0) @(posedge clock);
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("offline_range_min_union_find_core_tb passed");
      else $display("offline_range_min_union_find_core_tb failed");
      $finish;
   end
endmodule

// ===== offline_range_min_union_find_core.f =====
hdl/orm_uf_pkg.sv
hdl/offline_range_min_union_find_core.sv
verif/offline_range_min_union_find_core_checker.sv
verif/offline_range_min_union_find_core_tb.sv
